// ----- rtl/fbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared types and constants of the fixed block free list allocator.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  // Pool geometry
  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned IdxW     = $clog2(MaxSlots);   // slot index bits
  localparam int unsigned CntW     = IdxW + 1;           // count / list pointer bits

  // List terminator: one past the last slot
  localparam logic [CntW-1:0] ListEnd = CntW'(MaxSlots);

  // Field widths
  localparam int unsigned AddrW = 32;
  localparam int unsigned SizeW = 16;
  localparam int unsigned ProdW = IdxW + SizeW;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSlotCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegElementSize = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAreaBase    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CntW-1:0]  SlotCountRst   = CntW'(MaxSlots);
  localparam logic [SizeW-1:0] ElementSizeRst = 16'd64;
  localparam logic [AddrW-1:0] AreaBaseRst    = 32'd0;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD      = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_READ,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FCHK,
    S_DONE
  } state_e;

  // One entry of the next-slot table
  typedef struct packed {
    logic            used;
    logic [CntW-1:0] next;
  } entry_t;

  // Divider handshake toward the core
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/fbfl_div.sv -----
// ----------------------------------------------------------------------------
// fbfl_div
// Restoring divider, one quotient bit per cycle, 32-bit by 16-bit.
// ----------------------------------------------------------------------------
module fbfl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbfl_pkg::div_ctrl_t           ctrl_i,
  input  logic [fbfl_pkg::AddrW-1:0]    dividend_i,
  input  logic [fbfl_pkg::SizeW-1:0]    divisor_i,
  output fbfl_pkg::div_stat_t           stat_o,
  output logic [fbfl_pkg::AddrW-1:0]    quotient_o,
  output logic [fbfl_pkg::SizeW-1:0]    remainder_o
);

  localparam int unsigned CntBits = $clog2(fbfl_pkg::AddrW);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CntBits-1:0]           cnt_q, cnt_d;
  logic [fbfl_pkg::AddrW-1:0]   quo_q, quo_d;
  logic [fbfl_pkg::SizeW-1:0]   rem_q, rem_d;
  logic [fbfl_pkg::SizeW-1:0]   div_q, div_d;
  logic [fbfl_pkg::SizeW:0]     rem_sh;
  logic [fbfl_pkg::SizeW:0]     rem_sub;
  logic                         fits;

  // One restoring step
  assign rem_sh  = {rem_q, quo_q[fbfl_pkg::AddrW-1]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[fbfl_pkg::AddrW-2:0], fits};
      rem_d = fits ? rem_sub[fbfl_pkg::SizeW-1:0] : rem_sh[fbfl_pkg::SizeW-1:0];
      cnt_d = cnt_q + CntBits'(1);
      if (cnt_q == CntBits'(fbfl_pkg::AddrW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/fixed_block_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core
// Pool of equal-size slots with a linked free list held in a next-slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_ stream: tuser carries the operation
//   (allocate, free, lookup, clear), tdata the address and slot index.
//   One response per request leaves on the m_ stream.
//   The table is a 1024 x 12 synchronous RAM (next pointer and in-use flag),
//   one read and one write port; allocate reads and rewrites an entry,
//   lookup only reads, free and clear only write. Steps per request:
//     allocate, lookup: table read, multiply, add; any reject at accept goes
//     straight to the response, a lookup of a free slot after the read;
//     free: the bit-serial divider (32 steps) maps the address to a slot
//     index, then check and push; clear: the n effective slots, one entry per cycle.
//   A new request is taken in the cycle after the previous response is loaded.
//   After reset the table is chained by a sweep over all 1024 entries; no request is
//   accepted during it, configuration writes are taken as usual.
//   A stalled response holds in the output register; a request already
//   accepted finishes and waits in the done state until the output is free.
//   Configuration must be written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [fbfl_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  // Request stream
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [47:0]                     s_tdata_i,  // address[31:0], slot_index[41:32]
  input  logic [1:0]                      s_tuser_i,  // operation[1:0]
  // Response stream
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [55:0]                     m_tdata_o   // status[1:0], result_index[11:2],
                                                      // result_address[43:12], used_slots[54:44]
);

  localparam int unsigned IdxW  = fbfl_pkg::IdxW;
  localparam int unsigned CntW  = fbfl_pkg::CntW;
  localparam int unsigned AddrW = fbfl_pkg::AddrW;
  localparam int unsigned SizeW = fbfl_pkg::SizeW;
  localparam int unsigned ProdW = fbfl_pkg::ProdW;

  // Configuration registers
  logic [CntW-1:0]  slot_count_q;
  logic [SizeW-1:0] element_size_q;
  logic [AddrW-1:0] area_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q   <= fbfl_pkg::SlotCountRst;
      element_size_q <= fbfl_pkg::ElementSizeRst;
      area_base_q    <= fbfl_pkg::AreaBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbfl_pkg::RegSlotCount:   slot_count_q   <= cfg_data_i[CntW-1:0];
        fbfl_pkg::RegElementSize: element_size_q <= cfg_data_i[SizeW-1:0];
        fbfl_pkg::RegAreaBase:    area_base_q    <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  // Effective slot count, clamped to 1..MaxSlots
  logic [CntW-1:0] eff_n;
  always_comb begin
    if (slot_count_q == '0) begin
      eff_n = CntW'(1);
    end else if (slot_count_q > CntW'(fbfl_pkg::MaxSlots)) begin
      eff_n = CntW'(fbfl_pkg::MaxSlots);
    end else begin
      eff_n = slot_count_q;
    end
  end

  // Request fields
  fbfl_pkg::op_e   in_op;
  logic [AddrW-1:0] in_addr;
  logic [IdxW-1:0]  in_look;
  logic             s_fire;
  logic             m_fire;

  assign in_op   = fbfl_pkg::op_e'(s_tuser_i);
  assign in_addr = s_tdata_i[AddrW-1:0];
  assign in_look = s_tdata_i[AddrW+IdxW-1:AddrW];

  // State and datapath registers
  fbfl_pkg::state_e  state_q, state_d;
  fbfl_pkg::op_e     op_q, op_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [IdxW-1:0]   look_q, look_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  fbfl_pkg::status_e status_q, status_d;
  logic [IdxW-1:0]   ridx_q, ridx_d;
  logic [AddrW-1:0]  raddr_q, raddr_d;
  logic [CntW-1:0]   head_q, head_d;
  logic [CntW-1:0]   use_q, use_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic [IdxW-1:0]   sweep_last_q, sweep_last_d;
  logic              sweep_reply_q, sweep_reply_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  fbfl_pkg::status_e out_status_q, out_status_d;
  logic [IdxW-1:0]   out_ridx_q, out_ridx_d;
  logic [AddrW-1:0]  out_raddr_q, out_raddr_d;
  logic [CntW-1:0]   out_used_q, out_used_d;

  assign s_tready_o = (state_q == fbfl_pkg::S_IDLE);
  assign s_fire     = s_tvalid_i && s_tready_o;
  assign m_fire     = out_valid_q && m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_used_q, out_raddr_q, out_ridx_q, out_status_q};

  // Next-slot table
  fbfl_pkg::entry_t mem_q [fbfl_pkg::MaxSlots];
  fbfl_pkg::entry_t rd_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  fbfl_pkg::entry_t mem_wdata;
  logic [IdxW-1:0]  mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // Read port follows the incoming request: head for allocate, index for lookup
  assign mem_raddr = (in_op == fbfl_pkg::OP_ALLOC) ? head_q[IdxW-1:0] : in_look;

  // Address to index divider
  fbfl_pkg::div_ctrl_t div_ctrl;
  fbfl_pkg::div_stat_t div_stat;
  logic [AddrW-1:0]    div_quo;
  logic [SizeW-1:0]    div_rem;

  fbfl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (in_addr - area_base_q),
    .divisor_i   (element_size_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Early checks on the incoming request
  logic empty_pool;
  logic free_reject;
  logic look_reject;
  logic sweep_end;
  logic free_bad;
  logic out_free;

  assign empty_pool  = head_q[CntW-1];
  assign free_reject = (element_size_q == '0) || (in_addr < area_base_q);
  assign look_reject = {1'b0, in_look} >= eff_n;
  assign sweep_end   = (ptr_q == sweep_last_q);
  assign free_bad    = (div_rem != '0) || (div_quo >= AddrW'(eff_n));
  assign out_free    = !out_valid_q || m_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbfl_pkg::S_SWEEP: begin
        if (sweep_end) begin
          state_d = sweep_reply_q ? fbfl_pkg::S_DONE : fbfl_pkg::S_IDLE;
        end
      end
      fbfl_pkg::S_IDLE: begin
        if (s_fire) begin
          unique case (in_op)
            fbfl_pkg::OP_ALLOC:  state_d = empty_pool ? fbfl_pkg::S_DONE : fbfl_pkg::S_READ;
            fbfl_pkg::OP_FREE:   state_d = free_reject ? fbfl_pkg::S_DONE : fbfl_pkg::S_DIV;
            fbfl_pkg::OP_LOOKUP: state_d = look_reject ? fbfl_pkg::S_DONE : fbfl_pkg::S_READ;
            fbfl_pkg::OP_CLEAR:  state_d = fbfl_pkg::S_SWEEP;
            default:             state_d = fbfl_pkg::S_IDLE;
          endcase
        end
      end
      fbfl_pkg::S_READ: begin
        if (op_q == fbfl_pkg::OP_ALLOC || rd_q.used) begin
          state_d = fbfl_pkg::S_MUL;
        end else begin
          state_d = fbfl_pkg::S_DONE;
        end
      end
      fbfl_pkg::S_MUL:  state_d = fbfl_pkg::S_ADD;
      fbfl_pkg::S_ADD:  state_d = fbfl_pkg::S_DONE;
      fbfl_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_d = fbfl_pkg::S_FCHK;
        end
      end
      fbfl_pkg::S_FCHK: state_d = fbfl_pkg::S_DONE;
      fbfl_pkg::S_DONE: begin
        if (out_free) begin
          state_d = fbfl_pkg::S_IDLE;
        end
      end
      default: state_d = fbfl_pkg::S_IDLE;
    endcase
  end

  // Datapath, table access and output register
  always_comb begin
    op_d          = op_q;
    addr_d        = addr_q;
    look_d        = look_q;
    idx_d         = idx_q;
    prod_d        = prod_q;
    status_d      = status_q;
    ridx_d        = ridx_q;
    raddr_d       = raddr_q;
    head_d        = head_q;
    use_d         = use_q;
    ptr_d         = ptr_q;
    sweep_last_d  = sweep_last_q;
    sweep_reply_d = sweep_reply_q;
    mem_we        = 1'b0;
    mem_waddr     = ptr_q;
    mem_wdata     = '{used: 1'b0, next: fbfl_pkg::ListEnd};
    div_ctrl      = '{start: 1'b0};
    out_valid_d   = out_valid_q && !m_tready_i;
    out_status_d  = out_status_q;
    out_ridx_d    = out_ridx_q;
    out_raddr_d   = out_raddr_q;
    out_used_d    = out_used_q;

    unique case (state_q)
      // Chain slots 0..last, one entry per cycle
      fbfl_pkg::S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata.used = 1'b0;
        mem_wdata.next = sweep_end ? fbfl_pkg::ListEnd : ({1'b0, ptr_q} + CntW'(1));
        ptr_d     = ptr_q + IdxW'(1);
        if (sweep_end) begin
          head_d        = '0;
          use_d         = '0;
          sweep_reply_d = 1'b0;
        end
      end

      // Latch the request and run the early checks
      fbfl_pkg::S_IDLE: begin
        if (s_fire) begin
          op_d     = in_op;
          addr_d   = in_addr;
          look_d   = in_look;
          status_d = fbfl_pkg::ST_OK;
          ridx_d   = '0;
          raddr_d  = '0;
          unique case (in_op)
            fbfl_pkg::OP_ALLOC: begin
              if (empty_pool) status_d = fbfl_pkg::ST_EMPTY;
            end
            fbfl_pkg::OP_FREE: begin
              if (free_reject) begin
                status_d = fbfl_pkg::ST_BAD;
              end else begin
                div_ctrl.start = 1'b1;
              end
            end
            fbfl_pkg::OP_LOOKUP: begin
              if (look_reject) status_d = fbfl_pkg::ST_BAD;
            end
            fbfl_pkg::OP_CLEAR: begin
              ptr_d         = '0;
              sweep_last_d  = IdxW'(eff_n - CntW'(1));
              sweep_reply_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // Table entry is here: pop the head or check the in-use flag
      fbfl_pkg::S_READ: begin
        if (op_q == fbfl_pkg::OP_ALLOC) begin
          mem_we         = 1'b1;
          mem_waddr      = head_q[IdxW-1:0];
          mem_wdata.used = 1'b1;
          mem_wdata.next = rd_q.next;
          idx_d          = head_q[IdxW-1:0];
          ridx_d         = head_q[IdxW-1:0];
          head_d         = rd_q.next;
          use_d          = use_q + CntW'(1);
        end else begin
          idx_d  = look_q;
          ridx_d = look_q;
          if (!rd_q.used) status_d = fbfl_pkg::ST_NOT_USED;
        end
      end

      // Slot address: base plus index times size
      fbfl_pkg::S_MUL: prod_d = idx_q * element_size_q;
      fbfl_pkg::S_ADD: raddr_d = area_base_q + AddrW'(prod_q);

      fbfl_pkg::S_DIV: ;

      // Quotient is the slot index; check it and, if valid, push it on the list
      fbfl_pkg::S_FCHK: begin
        if (free_bad) begin
          status_d = fbfl_pkg::ST_BAD;
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = div_quo[IdxW-1:0];
          mem_wdata.used = 1'b0;
          mem_wdata.next = head_q;
          head_d         = {1'b0, div_quo[IdxW-1:0]};
          use_d          = use_q - CntW'(1);
          ridx_d         = div_quo[IdxW-1:0];
          raddr_d        = addr_q;
        end
      end

      // Hand the response to the output register
      fbfl_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_ridx_d   = ridx_q;
          out_raddr_d  = raddr_q;
          out_used_d   = use_q;
        end
      end

      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fbfl_pkg::S_SWEEP;
      head_q        <= '0;
      use_q         <= '0;
      ptr_q         <= '0;
      sweep_last_q  <= IdxW'(fbfl_pkg::MaxSlots - 1);
      sweep_reply_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_q        <= head_d;
      use_q         <= use_d;
      ptr_q         <= ptr_d;
      sweep_last_q  <= sweep_last_d;
      sweep_reply_q <= sweep_reply_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    look_q       <= look_d;
    idx_q        <= idx_d;
    prod_q       <= prod_d;
    status_q     <= status_d;
    ridx_q       <= ridx_d;
    raddr_q      <= raddr_d;
    out_status_q <= out_status_d;
    out_ridx_q   <= out_ridx_d;
    out_raddr_q  <= out_raddr_d;
    out_used_q   <= out_used_d;
  end

endmodule
